@@ rtl/rsfr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsfr_pkg: shared types and constants of the RS-485 frame receiver
// Holds the transaction payload structs, the sequencer states, the control
// and status structs of the serial CRC unit, and the frame constants.
// ----------------------------------------------------------------------------
package rsfr_pkg;

    localparam logic [7:0]  SYNC_BYTE   = 8'hAA;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [7:0]  FN_LEVEL    = 8'h03;
    localparam logic [7:0]  FN_ECHO_CRC = 8'h10;

    // Frame bytes kept for the reply, and the step values that matter.
    localparam int          FRAME_HEAD  = 6;
    localparam logic [3:0]  STEP_HEAD_END = 4'd5;
    localparam logic [3:0]  STEP_LAST   = 4'd7;
    localparam logic [2:0]  LAST_LEVEL  = 3'd5;
    localparam logic [2:0]  LAST_ECHO   = 3'd7;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] reply_byte;
        logic       reply_last;
        logic       level_write;
        logic [7:0] level_value;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CRC,
        ST_REPLY
    } t_state;

    typedef struct packed {
        logic       start;
        logic       clear;
        logic [7:0] data;
    } t_crc_ctrl;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [15:0] crc;
    } t_crc_stat;

endpackage
`default_nettype wire

@@ rtl/rs485_frame_receiver_crc16_reply.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rs485_frame_receiver_crc16_reply: RS-485 frame receiver with CRC-16 reply
// Hunts for the 0xAA 0xAA sync pair, collects an 8-byte frame, checks it
// with CRC-16/MODBUS and streams the reply for function 0x03 or 0x10.
// ----------------------------------------------------------------------------
// Each input transaction carries either a received byte or a bus-idle event.
// A bus-idle event, or a byte that fails the sync check, is absorbed in the
// cycle it is accepted and the block is ready again at once. A byte that
// enters the frame is folded into the CRC by a bit-serial unit, one bit per
// clock; once such a byte is accepted, the input stays stalled while the
// unit shifts it in and then while the sequencer reads the result. When
// the eighth byte completes a good frame with a known function, the
// sequencer then streams 6 (function 0x03) or 8 (function 0x10) reply
// transactions through a single output register, one per cycle while the
// output is not stalled; the input stays stalled until the last reply
// transaction is loaded into that register. Bad CRC or unknown functions
// are dropped silently, and the receiver goes back to hunting after every
// complete frame.
// ----------------------------------------------------------------------------
module rs485_frame_receiver_crc16_reply (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  rsfr_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output rsfr_pkg::t_out_item o_out_data
);

    rsfr_pkg::t_state    r_state, n_state;
    logic [3:0]          r_step, n_step;
    logic [15:0]         r_crc_head, n_crc_head;
    logic [2:0]          r_idx, n_idx;
    logic [2:0]          r_last, n_last;
    logic                r_fn_level, n_fn_level;
    logic                r_out_valid, n_out_valid;
    rsfr_pkg::t_out_item r_out_data, n_out_data;

    // Frame bytes 0..5; every entry is written before a reply reads it.
    logic [7:0]          r_fs [rsfr_pkg::FRAME_HEAD];
    logic                fs_we;

    rsfr_pkg::t_crc_ctrl crc_ctrl;
    rsfr_pkg::t_crc_stat crc_stat;

    rsfr_crc_unit u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (crc_ctrl),
        .o_stat  (crc_stat)
    );

    logic                in_accept;
    logic                out_free;
    rsfr_pkg::t_out_item item;

    assign o_in_stall = (r_state != rsfr_pkg::ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Reply item at the current index: head bytes, then the CRC of the head
    // low byte first.
    always_comb begin
        if (r_idx < 3'(rsfr_pkg::FRAME_HEAD)) begin
            item.reply_byte = r_fs[r_idx];
        end else if (r_idx == 3'd6) begin
            item.reply_byte = r_crc_head[7:0];
        end else begin
            item.reply_byte = r_crc_head[15:8];
        end
        item.reply_last  = (r_idx == r_last);
        item.level_write = r_fn_level && (r_idx == 3'd0);
        item.level_value = item.level_write ? r_fs[3] : 8'h00;
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_crc_head  = r_crc_head;
        n_idx       = r_idx;
        n_last      = r_last;
        n_fn_level  = r_fn_level;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        fs_we       = 1'b0;
        crc_ctrl    = '0;

        // The output register drains whenever the far side takes it.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            rsfr_pkg::ST_IDLE: begin
                if (in_accept) begin
                    if (i_in_data.operation) begin
                        // Bus idle: back to hunting.
                        n_step         = 4'd0;
                        crc_ctrl.clear = 1'b1;
                    end else if (r_step[3] || ((r_step < 4'd2) &&
                                 (i_in_data.rx_byte != rsfr_pkg::SYNC_BYTE))) begin
                        // Lost sync, or a step that cannot occur.
                        n_step         = 4'd0;
                        crc_ctrl.clear = 1'b1;
                    end else begin
                        fs_we          = (r_step < 4'(rsfr_pkg::FRAME_HEAD));
                        crc_ctrl.start = 1'b1;
                        crc_ctrl.data  = i_in_data.rx_byte;
                        n_state        = rsfr_pkg::ST_CRC;
                    end
                end
            end
            rsfr_pkg::ST_CRC: begin
                if (crc_stat.done) begin
                    if (r_step == rsfr_pkg::STEP_HEAD_END) begin
                        n_crc_head = crc_stat.crc;
                    end
                    if (r_step != rsfr_pkg::STEP_LAST) begin
                        n_step  = r_step + 4'd1;
                        n_state = rsfr_pkg::ST_IDLE;
                    end else begin
                        // Frame complete: check residue and function, then hunt.
                        n_step         = 4'd0;
                        crc_ctrl.clear = 1'b1;
                        n_idx          = 3'd0;
                        n_state        = rsfr_pkg::ST_IDLE;
                        if (crc_stat.crc == 16'h0000) begin
                            if (r_fs[2] == rsfr_pkg::FN_LEVEL) begin
                                n_last     = rsfr_pkg::LAST_LEVEL;
                                n_fn_level = 1'b1;
                                n_state    = rsfr_pkg::ST_REPLY;
                            end else if (r_fs[2] == rsfr_pkg::FN_ECHO_CRC) begin
                                n_last     = rsfr_pkg::LAST_ECHO;
                                n_fn_level = 1'b0;
                                n_state    = rsfr_pkg::ST_REPLY;
                            end
                        end
                    end
                end
            end
            rsfr_pkg::ST_REPLY: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = item;
                    n_idx       = r_idx + 3'd1;
                    if (r_idx == r_last) begin
                        n_state = rsfr_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = rsfr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rsfr_pkg::ST_IDLE;
            r_step      <= 4'd0;
            r_crc_head  <= 16'h0000;
            r_idx       <= 3'd0;
            r_last      <= 3'd0;
            r_fn_level  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_crc_head  <= n_crc_head;
            r_idx       <= n_idx;
            r_last      <= n_last;
            r_fn_level  <= n_fn_level;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        if (fs_we) begin
            r_fs[r_step[2:0]] <= i_in_data.rx_byte;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // The CRC unit only reports a finished byte while the sequencer waits.
    a_done_in_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        crc_stat.done |-> (r_state == rsfr_pkg::ST_CRC))
        else $error("CRC done outside the CRC wait state");

    // A byte that is not a sync byte during the hunt leaves the receiver hunting.
    a_sync_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !i_in_data.operation && (r_step < 4'd2) &&
         (i_in_data.rx_byte != rsfr_pkg::SYNC_BYTE))
        |=> (r_step == 4'd0) && (r_state == rsfr_pkg::ST_IDLE))
        else $error("receiver did not return to hunting after a bad sync byte");

    // The reply index never runs past the last byte of the reply.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rsfr_pkg::ST_REPLY) |-> (r_idx <= r_last))
        else $error("reply index beyond the end of the reply");

    // The level flag rides on the first reply byte, which is a sync byte.
    a_level_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.level_write)
        |-> (r_out_data.reply_byte == rsfr_pkg::SYNC_BYTE))
        else $error("level write on a byte other than the first sync byte");

    // The CRC unit is idle whenever the receiver takes a transaction.
    a_crc_idle_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |-> !crc_stat.busy)
        else $error("transaction accepted while the CRC unit is busy");

endmodule
`default_nettype wire

@@ rtl/rsfr_crc_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsfr_crc_unit: bit-serial CRC-16/MODBUS engine
// Folds one byte into the running CRC, one bit per clock, and pulses done
// when the new value is in place; clear reloads the initial value.
// ----------------------------------------------------------------------------
module rsfr_crc_unit (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  rsfr_pkg::t_crc_ctrl i_ctrl,
    output rsfr_pkg::t_crc_stat o_stat
);

    logic [15:0] r_crc, n_crc;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;

    always_comb begin
        n_crc  = r_crc;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_ctrl.clear) begin
            n_crc = rsfr_pkg::CRC_INIT;
        end else if (i_ctrl.start) begin
            n_crc  = r_crc ^ {8'h00, i_ctrl.data};
            n_cnt  = 3'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // One shift of the reflected polynomial division.
            n_crc = {1'b0, r_crc[15:1]} ^ (r_crc[0] ? rsfr_pkg::CRC_POLY : 16'h0000);
            n_cnt = r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= rsfr_pkg::CRC_INIT;
            r_cnt  <= 3'd0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_crc  <= n_crc;
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.crc  = r_crc;

endmodule
`default_nettype wire
